// ----- hw/rtl/lsct_pkg.sv -----
package lsct_pkg;

  // Fixed field widths of the channel index and the configuration port.
  localparam int unsigned ChanW    = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned SpanW    = 10;

  localparam logic [SpanW-1:0] MinSpanReset = 10'd200;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCalMode = 2'd0,
    CfgMinSpan = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ModeDigitize  = 2'd0,
    ModeCalAlways = 2'd1,
    ModeSpanCheck = 2'd2
  } cal_mode_e;

endpackage

// ----- hw/rtl/lsct_if.sv -----
// Sample request channel.
interface lsct_if
  import lsct_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [ChanW-1:0]       channel;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

// Result request channel.
interface lsct_out_if
  import lsct_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [ChanW-1:0]       channel_out;
  logic                   line_bit;
  logic [SAMPLE_BITS-1:0] threshold_out;
  logic                   all_ready;

  modport source (output valid, channel_out, line_bit, threshold_out, all_ready,
                  input ready);
  modport sink   (input valid, channel_out, line_bit, threshold_out, all_ready,
                  output ready);
endinterface

// Configuration write channel.
interface lsct_cfg_if
  import lsct_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/line_sensor_calibrate_threshold_core.sv -----
// Channel  Dir  Handshake      Payload
// in_i     in   valid/ready    channel, sample
// out_o    out  valid/ready    channel_out, line_bit, threshold_out, all_ready
// cfg_i    in   valid/ready    index, data (cal_mode, min_span)
//
// One request per clock while out_o is not stalled: a sample is registered,
// then its channel's white/black/threshold flops are read, updated and
// written in the calibration modes while the result enters the output register.
// Reset clears every channel to white all ones, black zero, threshold half
// scale and ready low; cal_mode resets to digitize, min_span to 200.
// A stalled output holds the sample stage; in_i keeps taking requests as
// long as the sample stage can move or is empty.
module line_sensor_calibrate_threshold_core
  import lsct_pkg::*;
#(
  parameter int unsigned NUM_SENSORS = 12,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsct_if.sink        in_i,
  lsct_out_if.source  out_o,
  lsct_cfg_if.sink    cfg_i
);

  localparam logic [SAMPLE_BITS-1:0] SampleMax = '1;
  localparam logic [SAMPLE_BITS-1:0] ThrReset  = SampleMax >> 1;
  localparam int unsigned            CmpW      = (SAMPLE_BITS > SpanW) ? SAMPLE_BITS : SpanW;

  // Configuration registers.
  logic [1:0]       cal_mode_q;
  logic [SpanW-1:0] min_span_q;

  // Per-channel calibration state.
  logic [SAMPLE_BITS-1:0] white_q [NUM_SENSORS];
  logic [SAMPLE_BITS-1:0] black_q [NUM_SENSORS];
  logic [SAMPLE_BITS-1:0] thr_q   [NUM_SENSORS];
  logic [NUM_SENSORS-1:0] rdy_q, rdy_d;

  // Sample stage.
  logic                   s1_valid_q;
  logic [ChanW-1:0]       s1_chan_q;
  logic [SAMPLE_BITS-1:0] s1_sample_q;
  logic                   s1_adv;

  // Output register.
  logic                   out_valid_q;
  logic [ChanW-1:0]       out_chan_q;
  logic                   out_line_q;
  logic [SAMPLE_BITS-1:0] out_thr_q;
  logic                   out_all_q;

  // Update path.
  logic                   hit;
  logic [SAMPLE_BITS-1:0] cur_white, cur_black, cur_thr;
  logic [SAMPLE_BITS-1:0] new_white, new_black, new_thr;
  logic [SAMPLE_BITS:0]   ext_sum;
  logic [SAMPLE_BITS-1:0] mid;
  logic [SAMPLE_BITS-1:0] span;
  logic                   span_ok;
  logic                   upd_ext, upd_rdy, rdy_bit;
  logic                   line_d;
  logic [SAMPLE_BITS-1:0] thr_out_d;

  // The configuration port never stalls; the user must write only while idle, the block does not enforce it.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_mode_q <= ModeDigitize;
      min_span_q <= MinSpanReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgCalMode: cal_mode_q <= cfg_i.data[1:0];
        CfgMinSpan: min_span_q <= cfg_i.data[SpanW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the sample stage when the output register is free or drains.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_chan_q   <= in_i.channel;
      s1_sample_q <= in_i.sample;
    end
  end

  // Select the addressed channel; out-of-range channels hit nothing.
  assign hit = int'(s1_chan_q) < int'(NUM_SENSORS);

  always_comb begin
    cur_white = '0;
    cur_black = '0;
    cur_thr   = '0;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      if (int'(s1_chan_q) == k) begin
        cur_white = white_q[k];
        cur_black = black_q[k];
        cur_thr   = thr_q[k];
      end
    end
  end

  assign new_white = (s1_sample_q < cur_white) ? s1_sample_q : cur_white;
  assign new_black = (s1_sample_q > cur_black) ? s1_sample_q : cur_black;
  assign ext_sum   = {1'b0, new_black} + {1'b0, new_white};
  assign mid       = ext_sum[SAMPLE_BITS:1];
  assign span      = new_black - new_white;
  // Black below white never counts as a valid span.
  assign span_ok   = (new_black > new_white) && (CmpW'(span) > CmpW'(min_span_q));

  always_comb begin
    upd_ext = 1'b0;
    upd_rdy = 1'b0;
    rdy_bit = 1'b0;
    new_thr = cur_thr;
    unique case (cal_mode_q)
      ModeCalAlways: begin
        upd_ext = 1'b1;
        // Either extreme moving re-centers the threshold.
        if ((new_white != cur_white) || (new_black != cur_black)) begin
          new_thr = mid;
        end
      end
      ModeSpanCheck: begin
        upd_ext = 1'b1;
        upd_rdy = 1'b1;
        rdy_bit = span_ok;
        if (span_ok) begin
          new_thr = mid;
        end
      end
      default: ;  // digitize only, also for the unused mode code
    endcase
  end

  always_comb begin
    rdy_d = rdy_q;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      if (hit && upd_rdy && (int'(s1_chan_q) == k)) begin
        rdy_d[k] = rdy_bit;
      end
    end
  end

  assign thr_out_d = hit ? new_thr : '0;
  assign line_d    = hit && (s1_sample_q > new_thr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SENSORS; k++) begin
        white_q[k] <= SampleMax;
        black_q[k] <= '0;
        thr_q[k]   <= ThrReset;
      end
      rdy_q <= '0;
    end else if (s1_adv) begin
      for (int k = 0; k < NUM_SENSORS; k++) begin
        if (hit && upd_ext && (int'(s1_chan_q) == k)) begin
          white_q[k] <= new_white;
          black_q[k] <= new_black;
          thr_q[k]   <= new_thr;
        end
      end
      rdy_q <= rdy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_chan_q <= s1_chan_q;
      out_line_q <= line_d;
      out_thr_q  <= thr_out_d;
      out_all_q  <= &rdy_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.channel_out   = out_chan_q;
  assign out_o.line_bit      = out_line_q;
  assign out_o.threshold_out = out_thr_q;
  assign out_o.all_ready     = out_all_q;

endmodule

// ----- hw/rtl/lsct_checker.sv -----
module lsct_checker
  import lsct_pkg::*;
#(
  parameter int unsigned NUM_SENSORS = 12,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [ChanW-1:0]       channel_out_i,
  input logic                   line_bit_i,
  input logic [SAMPLE_BITS-1:0] threshold_out_i,
  input logic                   all_ready_i
);

  localparam logic [SAMPLE_BITS-1:0] SampleMax = '1;

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(channel_out_i)
      && $stable(line_bit_i) && $stable(threshold_out_i) && $stable(all_ready_i))
    else $error("stalled result changed");

  // Out-of-range channel gives a zero threshold and no line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (int'(channel_out_i) >= int'(NUM_SENSORS))
      |-> !line_bit_i && (threshold_out_i == '0))
    else $error("out-of-range channel result not cleared");

  // A line hit needs a threshold below full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && line_bit_i |-> threshold_out_i != SampleMax)
    else $error("line bit with full-scale threshold");

  // A new result follows a request accepted and passed through the sample stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without request");

endmodule

bind line_sensor_calibrate_threshold_core lsct_checker #(
  .NUM_SENSORS(NUM_SENSORS),
  .SAMPLE_BITS(SAMPLE_BITS)
) u_lsct_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .channel_out_i  (out_o.channel_out),
  .line_bit_i     (out_o.line_bit),
  .threshold_out_i(out_o.threshold_out),
  .all_ready_i    (out_o.all_ready)
);
